// ----- design/sps_pkg.sv -----
package sps_pkg;

  typedef enum logic [1:0] {
    OP_ENTRY_BYTE = 2'd0,
    OP_ENTRY_LEN  = 2'd1,
    OP_KEY_BYTE   = 2'd2,
    OP_SEARCH     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_index;
    logic [7:0] byte_pos;
    logic [7:0] data_byte;
    logic [7:0] length;
    logic [7:0] low_index;
    logic [7:0] high_index;
    logic       find_lowest;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] match_index;
  } out_item_t;

endpackage

// ----- design/sps_ram.sv -----
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/sps_front.sv -----
module sps_front #(
  parameter int QD = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  sps_pkg::in_item_t in_item,
  output logic             q_valid,
  output sps_pkg::in_item_t q_item,
  input  logic             q_take
);
  import sps_pkg::*;
  localparam int AW = (QD > 1) ? $clog2(QD) : 1;

  in_item_t       buf_r [QD];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_push, do_pop;

  // queue of accepted items; the back drains it one item at a time
  assign full    = (cnt_r == (AW+1)'(QD));
  assign do_push = push && !full;
  assign q_valid = (cnt_r != '0);
  assign do_pop  = q_take && q_valid;
  assign q_item  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) buf_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(QD-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(QD-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ----- design/sps_back.sv -----
module sps_back #(
  parameter int ENTRIES = 256,
  parameter int MAX_LEN = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sps_pkg::in_item_t q_item,
  output logic              q_take,
  output logic              out_valid,
  output sps_pkg::out_item_t out_item,
  input  logic              out_take
);
  import sps_pkg::*;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SD = ENTRIES * MAX_LEN;
  localparam int SW = $clog2(SD);
  localparam int GW = ((EW > 8) ? EW : 8) + 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROBE = 5'b00010,
    S_LWAIT = 5'b00100,
    S_CMP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          st_r, st_nxt;
  logic signed [GW-1:0] lo_r, hi_r, lo_nxt, hi_nxt, g_r, g_nxt;
  logic [8:0]      klen_r, klen_nxt, tl_r, tl_nxt;
  logic [8:0]      i_r, i_nxt;
  logic            lowest_r, lowest_nxt, seen_r, seen_nxt;
  logic [7:0]      seen_idx_r, seen_idx_nxt;
  logic            ov_r, ov_nxt;
  out_item_t       oi_r, oi_nxt;

  logic            es_we, el_we, ks_we;
  logic [SW-1:0]   es_waddr, es_raddr;
  logic [7:0]      es_rdata, el_wdata, el_rdata, ks_rdata;
  logic [EW-1:0]   el_addr_w, el_raddr;
  logic [LW-1:0]   ks_raddr;
  logic [8:0]      len9;
  logic [GW-1:0]   hi_lim;

  // loads finish in the cycle they are taken
  always_comb begin
    es_we = 1'b0; el_we = 1'b0; ks_we = 1'b0;
    if (st_r == S_IDLE && q_valid) begin
      unique case (opcode_t'(q_item.opcode))
        OP_ENTRY_BYTE: es_we = (32'(q_item.entry_index) < ENTRIES)
                            && ({1'b0, q_item.byte_pos} < 9'(MAX_LEN));
        OP_ENTRY_LEN:  el_we = (32'(q_item.entry_index) < ENTRIES);
        OP_KEY_BYTE:   ks_we = ({1'b0, q_item.byte_pos} < 9'(MAX_LEN));
        default: ;
      endcase
    end
  end

  assign es_waddr = SW'(32'(q_item.entry_index) * MAX_LEN + 32'(q_item.byte_pos));
  assign el_addr_w = EW'(q_item.entry_index);
  assign el_wdata = ({1'b0, q_item.length} > 9'(MAX_LEN)) ? 8'(MAX_LEN) : q_item.length;
  assign es_raddr = SW'(32'(g_r[EW-1:0]) * MAX_LEN + 32'(i_r));
  assign el_raddr = g_nxt[EW-1:0];
  assign ks_raddr = LW'(i_r);

  sps_ram #(.WIDTH(8), .DEPTH(SD)) u_es (
    .clk, .we(es_we), .waddr(es_waddr), .wdata(q_item.data_byte),
    .raddr(es_raddr), .rdata(es_rdata));
  sps_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_el (
    .clk, .we(el_we), .waddr(el_addr_w), .wdata(el_wdata),
    .raddr(el_raddr), .rdata(el_rdata));
  sps_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ks (
    .clk, .we(ks_we), .waddr(LW'(q_item.byte_pos)), .wdata(q_item.data_byte),
    .raddr(ks_raddr), .rdata(ks_rdata));

  assign len9   = {1'b0, q_item.length};
  assign hi_lim = (32'(q_item.high_index) > ENTRIES - 1) ? GW'(ENTRIES-1)
                                                         : GW'(q_item.high_index);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    st_nxt = st_r; lo_nxt = lo_r; hi_nxt = hi_r; g_nxt = g_r;
    klen_nxt = klen_r; tl_nxt = tl_r; i_nxt = i_r; lowest_nxt = lowest_r;
    seen_nxt = seen_r; seen_idx_nxt = seen_idx_r;
    ov_nxt = ov_r && !out_take; oi_nxt = oi_r;
    q_take = 1'b0;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        if (opcode_t'(q_item.opcode) == OP_SEARCH) begin
          if (!ov_r || out_take) begin
            q_take = 1'b1;
            lo_nxt = GW'(q_item.low_index);
            hi_nxt = hi_lim;
            klen_nxt = (len9 > 9'(MAX_LEN)) ? 9'(MAX_LEN) : len9;
            lowest_nxt = q_item.find_lowest;
            seen_nxt = 1'b0; seen_idx_nxt = '0;
            st_nxt = S_PROBE;
          end
        end else q_take = 1'b1;
      end
      S_PROBE: begin
        if (lo_r > hi_r) st_nxt = S_DONE;
        else begin
          g_nxt = lo_r + ((hi_r - lo_r) >>> 1);
          i_nxt = '0;
          st_nxt = S_LWAIT;
        end
      end
      S_LWAIT: begin
        // length read issued last cycle; byte 0 read issued now
        tl_nxt = ({1'b0, el_rdata} > klen_r) ? klen_r : {1'b0, el_rdata};
        st_nxt = S_CMP;
        i_nxt = i_r + 1'b1;
      end
      S_CMP: begin
        // compare byte i_r-1 read last cycle; keep reading the next
        if ((i_r - 1'b1) >= tl_r) begin
          if (tl_r == klen_r) begin
            seen_nxt = 1'b1; seen_idx_nxt = 8'(g_r);
            if (!lowest_r) st_nxt = S_DONE;
            else begin hi_nxt = g_r - 1'b1; st_nxt = S_PROBE; end
          end else begin lo_nxt = g_r + 1'b1; st_nxt = S_PROBE; end
        end else if (es_rdata != ks_rdata) begin
          if (es_rdata > ks_rdata) hi_nxt = g_r - 1'b1;
          else lo_nxt = g_r + 1'b1;
          st_nxt = S_PROBE;
        end else i_nxt = i_r + 1'b1;
      end
      S_DONE: begin
        if (!ov_r || out_take) begin
          ov_nxt = 1'b1;
          oi_nxt.found = seen_r;
          oi_nxt.match_index = seen_idx_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; g_r <= g_nxt; klen_r <= klen_nxt;
    tl_r <= tl_nxt; i_r <= i_nxt; lowest_r <= lowest_nxt;
    seen_idx_r <= seen_idx_nxt; oi_r <= oi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; seen_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; seen_r <= seen_nxt;
    end
  end
endmodule

// ----- design/sorted_prefix_search_core.sv -----
// Load items: one per cycle while the back end is idle, written to the tables as the back end takes them.
// Search: from the queue head, each probe runs S_PROBE, S_LWAIT, then S_CMP over the compared bytes
// until one differs; it ends at S_DONE on an empty range, or on a match when find_lowest is clear.
// The binary-search probe loop in the back end, one RAM byte read a cycle, sets the rate.
// Result holds in an output register until popped; loads behind it go on, a search waits.
// Reset (rst_n low, synchronous) empties the queue and output; tables are not cleared.
module sorted_prefix_search_core #(
  parameter int ENTRIES = 256,
  parameter int MAX_LEN = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sps_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sps_pkg::out_item_t out_item
);
  import sps_pkg::*;

  logic     q_valid, q_take, out_valid;
  in_item_t q_item;

  // front: hold accepted requests in a short queue
  sps_front #(.QD(2)) u_front (
    .clk, .rst_n, .push, .full, .in_item,
    .q_valid, .q_item, .q_take);

  // back: carry out loads and searches
  sps_back #(.ENTRIES(ENTRIES), .MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take,
    .out_valid, .out_item, .out_take(pop));

  assign empty = !out_valid;

  // a result never shows found low with a nonzero index
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.found) |-> (out_item.match_index == '0))
    else $error("nonzero index on not found");
  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result lost");
endmodule
